// File: rtl/fsr_pkg.sv
// Package for the framed serial receiver: receive phase type, status codes,
// register indexes and frame constants. Depends on nothing.
`timescale 1ns / 1ps

package fsr_pkg;

    // Receive phase, one-hot coded.
    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_ID     = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CSUM   = 6'b010000,
        PH_FOOTER = 6'b100000
    } phase_t;

    // Status codes of a result word.
    localparam logic [2:0] ST_HUNT     = 3'd0;
    localparam logic [2:0] ST_IN       = 3'd1;
    localparam logic [2:0] ST_DATA     = 3'd2;
    localparam logic [2:0] ST_OK       = 3'd3;
    localparam logic [2:0] ST_CSUM_ERR = 3'd4;
    localparam logic [2:0] ST_FOOT_ERR = 3'd5;
    localparam logic [2:0] ST_LEN_ERR  = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_HEADER_BYTE  = 3'd0;
    localparam logic [2:0] REG_FOOTER_BYTE  = 3'd1;
    localparam logic [2:0] REG_PAYLOAD_ID_A = 3'd2;
    localparam logic [2:0] REG_PAYLOAD_ID_B = 3'd3;
    localparam logic [2:0] REG_PAYLOAD_ID_C = 3'd4;
    localparam logic [2:0] REG_PAYLOAD_ID_D = 3'd5;

    // Reset values of the frame delimiters.
    localparam logic [7:0] HEADER_RESET = 8'h02;
    localparam logic [7:0] FOOTER_RESET = 8'h03;

    // The length byte carries the payload count plus this offset.
    localparam logic [7:0] LEN_OFFSET = 8'h10;

endpackage

// File: rtl/framed_serial_receiver.sv
// Framed serial receiver: deframes header, id, length, payload, XOR checksum
// and footer, and gives one status word for every received byte.
// An accepted input word gives its result word in the next cycle.
// One word is accepted per cycle while the result side drains: the phase update and the XOR are short
// logic between the state registers and the single result register.
// Reset (rst_n low, asynchronous) returns to hunting for a header, clears the
// frame state and loads header 0x02, footer 0x03 and payload ids of zero.
// Depends on fsr_pkg.
`timescale 1ns / 1ps

module framed_serial_receiver
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    // Received bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    // Status words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] frame_id, [15:8] payload_byte,
                                   // [23:16] payload_index, [31:24] payload_length
    output logic [2:0]  m_tuser    // [2:0] status
);

    // Configuration registers.
    logic [7:0] header_byte_reg;
    logic [7:0] footer_byte_reg;
    logic [7:0] payload_id_a_reg;
    logic [7:0] payload_id_b_reg;
    logic [7:0] payload_id_c_reg;
    logic [7:0] payload_id_d_reg;

    // Frame state.
    fsr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] current_id_reg, current_id_next;
    logic [7:0] current_length_reg, current_length_next;
    logic [7:0] byte_counter_reg, byte_counter_next;
    logic [7:0] running_xor_reg, running_xor_next;

    // Result register.
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg;

    logic [2:0]  status_next;
    logic [7:0]  pbyte_next;
    logic [7:0]  pindex_next;
    logic [7:0]  count_inc;
    logic        id_has_payload;
    logic        accept;

    // A new byte is taken whenever the result register is empty or is being
    // drained in the same cycle, so bytes can stream at one per cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Configuration writes; indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg  <= fsr_pkg::HEADER_RESET;
            footer_byte_reg  <= fsr_pkg::FOOTER_RESET;
            payload_id_a_reg <= 8'h00;
            payload_id_b_reg <= 8'h00;
            payload_id_c_reg <= 8'h00;
            payload_id_d_reg <= 8'h00;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fsr_pkg::REG_HEADER_BYTE:  header_byte_reg  <= cfg_wdata;
                fsr_pkg::REG_FOOTER_BYTE:  footer_byte_reg  <= cfg_wdata;
                fsr_pkg::REG_PAYLOAD_ID_A: payload_id_a_reg <= cfg_wdata;
                fsr_pkg::REG_PAYLOAD_ID_B: payload_id_b_reg <= cfg_wdata;
                fsr_pkg::REG_PAYLOAD_ID_C: payload_id_c_reg <= cfg_wdata;
                fsr_pkg::REG_PAYLOAD_ID_D: payload_id_d_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Only the four configured ids carry a length byte and a payload.
    assign id_has_payload = (s_tdata == payload_id_a_reg) ||
                            (s_tdata == payload_id_b_reg) ||
                            (s_tdata == payload_id_c_reg) ||
                            (s_tdata == payload_id_d_reg);

    assign count_inc = byte_counter_reg + 8'd1;

    // Phase logic for one received byte. The header value has no special
    // meaning inside a frame; it is taken as whatever the phase expects.
    always_comb
    begin
        phase_next          = phase_reg;
        current_id_next     = current_id_reg;
        current_length_next = current_length_reg;
        byte_counter_next   = byte_counter_reg;
        running_xor_next    = running_xor_reg;
        status_next         = fsr_pkg::ST_IN;
        pbyte_next          = 8'h00;
        pindex_next         = 8'h00;

        case (phase_reg)
            fsr_pkg::PH_ID:
            begin
                current_id_next     = s_tdata;
                current_length_next = 8'h00;
                running_xor_next    = running_xor_reg ^ s_tdata;
                phase_next          = id_has_payload ? fsr_pkg::PH_LEN : fsr_pkg::PH_CSUM;
            end
            fsr_pkg::PH_LEN:
            begin
                if (s_tdata < fsr_pkg::LEN_OFFSET)
                begin
                    // A length byte below the offset cannot encode a count.
                    status_next = fsr_pkg::ST_LEN_ERR;
                    phase_next  = fsr_pkg::PH_HEADER;
                end
                else
                begin
                    current_length_next = s_tdata - fsr_pkg::LEN_OFFSET;
                    byte_counter_next   = 8'h00;
                    running_xor_next    = running_xor_reg ^ s_tdata;
                    // An empty payload goes straight to the checksum.
                    phase_next = (s_tdata == fsr_pkg::LEN_OFFSET) ?
                                 fsr_pkg::PH_CSUM : fsr_pkg::PH_DATA;
                end
            end
            fsr_pkg::PH_DATA:
            begin
                status_next       = fsr_pkg::ST_DATA;
                pbyte_next        = s_tdata;
                pindex_next       = byte_counter_reg;
                byte_counter_next = count_inc;
                running_xor_next  = running_xor_reg ^ s_tdata;
                if (count_inc >= current_length_reg)
                begin
                    phase_next = fsr_pkg::PH_CSUM;
                end
            end
            fsr_pkg::PH_CSUM:
            begin
                if (s_tdata == running_xor_reg)
                begin
                    phase_next = fsr_pkg::PH_FOOTER;
                end
                else
                begin
                    status_next = fsr_pkg::ST_CSUM_ERR;
                    phase_next  = fsr_pkg::PH_HEADER;
                end
            end
            fsr_pkg::PH_FOOTER:
            begin
                status_next = (s_tdata == footer_byte_reg) ?
                              fsr_pkg::ST_OK : fsr_pkg::ST_FOOT_ERR;
                phase_next  = fsr_pkg::PH_HEADER;
            end
            default:
            begin
                // Hunting for a header; illegal phase codes land here too.
                if (s_tdata == header_byte_reg)
                begin
                    current_id_next     = 8'h00;
                    current_length_next = 8'h00;
                    byte_counter_next   = 8'h00;
                    running_xor_next    = s_tdata;
                    phase_next          = fsr_pkg::PH_ID;
                end
                else
                begin
                    status_next = fsr_pkg::ST_HUNT;
                    phase_next  = fsr_pkg::PH_HEADER;
                end
            end
        endcase
    end

    // While hunting, the id and length fields of the result read as zero.
    always_comb
    begin
        if (status_next == fsr_pkg::ST_HUNT)
        begin
            m_tdata_next = {8'h00, pindex_next, pbyte_next, 8'h00};
        end
        else
        begin
            m_tdata_next = {current_length_next, pindex_next, pbyte_next, current_id_next};
        end
    end

    // Frame state and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= fsr_pkg::PH_HEADER;
            current_id_reg     <= 8'h00;
            current_length_reg <= 8'h00;
            byte_counter_reg   <= 8'h00;
            running_xor_reg    <= 8'h00;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg          <= phase_next;
                current_id_reg     <= current_id_next;
                current_length_reg <= current_length_next;
                byte_counter_reg   <= byte_counter_next;
                running_xor_reg    <= running_xor_next;
                m_tvalid_reg       <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= status_next;
        end
    end

endmodule

// File: verif/tb_framed_serial_receiver.sv
`timescale 1ns / 1ps
// Self-checking testbench for framed_serial_receiver: byte streams go in on the slave port.
// Every status word on the master port is compared with an in-bench predictor.
// Depends on fsr_pkg and the receiver RTL.

module tb_framed_serial_receiver;

    localparam int         CLK_HALF_NS  = 5;
    localparam int         TIMEOUT_NS   = 5_000_000;
    localparam int         PHASE_WORDS  = 320;
    localparam int         MAX_PAYLOAD  = 239;
    localparam int         MAX_REPORTS  = 10;
    localparam int         DRAIN_CYCLES = 8;
    // Indexes past the last register. Writes to them must leave the block untouched.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // One status word, split into its fields.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame_id;
        logic [7:0] pbyte;
        logic [7:0] pindex;
        logic [7:0] plength;
    } status_word_t;

    // One row of the directed table. When typed is set, the word in want is the
    // expected result. Otherwise the predictor supplies the expected result.
    typedef struct packed {
        logic [7:0]   rx;
        logic         typed;
        status_word_t want;
    } dir_row_t;

    // These are the ready patterns of the result side. Each pattern holds for a random stretch.
    typedef enum int {
        RDY_OPEN,
        RDY_LIGHT,
        RDY_HEAVY,
        RDY_PERIODIC
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // The predictor keeps its own copy of the registers and of the receive state.
    logic [7:0]      hdr_val;
    logic [7:0]      ftr_val;
    logic [7:0]      pid [4];
    fsr_pkg::phase_t rx_ph;
    logic [7:0]      cur_id;
    logic [7:0]      cur_len;
    logic [7:0]      pay_cnt;
    logic [7:0]      xor_acc;

    // This queue holds the expected status words, oldest first.
    status_word_t status_q [$];
    int           mismatch_count = 0;
    int           words_sent     = 0;
    int           burst_left     = 0;
    ready_mode_t  ready_mode     = RDY_OPEN;
    int           ready_run      = 0;
    int           cycle_no       = 0;

    // The directed table uses the reset register values: header 0x02, footer 0x03 and all
    // payload ids zero. Each frame with id 0 therefore carries a length byte.
    dir_row_t dir_rows [24] = '{
        // Bytes outside a frame give a hunting word with all fields zero.
        '{8'h00, 1'b1, '{fsr_pkg::ST_HUNT, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hFF, 1'b1, '{fsr_pkg::ST_HUNT, 8'h00, 8'h00, 8'h00, 8'h00}},
        // This is a frame without a payload: header, id 5, checksum 0x07, footer.
        '{fsr_pkg::HEADER_RESET, 1'b1, '{fsr_pkg::ST_IN, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h05, 1'b0, '0},
        '{8'h07, 1'b0, '0},
        '{fsr_pkg::FOOTER_RESET, 1'b1, '{fsr_pkg::ST_OK, 8'h05, 8'h00, 8'h00, 8'h00}},
        // A length byte below the offset is a length error.
        '{fsr_pkg::HEADER_RESET, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h0F, 1'b1, '{fsr_pkg::ST_LEN_ERR, 8'h00, 8'h00, 8'h00, 8'h00}},
        // A zero length skips the payload. The checksum comes right after the length byte.
        '{fsr_pkg::HEADER_RESET, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h10, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{fsr_pkg::FOOTER_RESET, 1'b1, '{fsr_pkg::ST_OK, 8'h00, 8'h00, 8'h00, 8'h00}},
        // This frame has two payload bytes. The first one equals the header value and is plain
        // data here. The checksum after them is wrong.
        '{fsr_pkg::HEADER_RESET, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{fsr_pkg::HEADER_RESET, 1'b0, '0},
        '{8'hFF, 1'b1, '{fsr_pkg::ST_DATA, 8'h00, 8'hFF, 8'h01, 8'h02}},
        '{8'h00, 1'b1, '{fsr_pkg::ST_CSUM_ERR, 8'h00, 8'h00, 8'h00, 8'h02}},
        // This frame has a good checksum and a wrong footer byte.
        '{fsr_pkg::HEADER_RESET, 1'b0, '0},
        '{8'h09, 1'b0, '0},
        '{8'h0B, 1'b0, '0},
        '{8'h04, 1'b1, '{fsr_pkg::ST_FOOT_ERR, 8'h09, 8'h00, 8'h00, 8'h00}}
    };

    framed_serial_receiver dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Returns 1 when the id matches one of the four payload ids, so the frame carries a length byte.
    function automatic logic carries_payload(input logic [7:0] id);
        return id == pid[0] || id == pid[1] || id == pid[2] || id == pid[3];
    endfunction

    // Advances the predicted receive state by one byte and returns the status word
    // that this byte must produce.
    function automatic status_word_t receive_byte(input logic [7:0] b);
        status_word_t w;
        w        = '0;
        w.status = fsr_pkg::ST_IN;
        case (rx_ph)
            fsr_pkg::PH_ID:
            begin
                cur_id  = b;
                cur_len = 8'h00;
                xor_acc = xor_acc ^ b;
                rx_ph   = carries_payload(b) ? fsr_pkg::PH_LEN : fsr_pkg::PH_CSUM;
            end
            fsr_pkg::PH_LEN:
            begin
                if (b < fsr_pkg::LEN_OFFSET)
                begin
                    w.status = fsr_pkg::ST_LEN_ERR;
                    rx_ph    = fsr_pkg::PH_HEADER;
                end
                else
                begin
                    cur_len = b - fsr_pkg::LEN_OFFSET;
                    pay_cnt = 8'h00;
                    xor_acc = xor_acc ^ b;
                    rx_ph   = (cur_len == 8'h00) ? fsr_pkg::PH_CSUM : fsr_pkg::PH_DATA;
                end
            end
            fsr_pkg::PH_DATA:
            begin
                w.status = fsr_pkg::ST_DATA;
                w.pbyte  = b;
                w.pindex = pay_cnt;
                pay_cnt  = pay_cnt + 8'h01;
                xor_acc  = xor_acc ^ b;
                if (pay_cnt >= cur_len)
                    rx_ph = fsr_pkg::PH_CSUM;
            end
            fsr_pkg::PH_CSUM:
            begin
                if (b == xor_acc)
                    rx_ph = fsr_pkg::PH_FOOTER;
                else
                begin
                    w.status = fsr_pkg::ST_CSUM_ERR;
                    rx_ph    = fsr_pkg::PH_HEADER;
                end
            end
            fsr_pkg::PH_FOOTER:
            begin
                w.status = (b == ftr_val) ? fsr_pkg::ST_OK : fsr_pkg::ST_FOOT_ERR;
                rx_ph    = fsr_pkg::PH_HEADER;
            end
            default:
            begin
                // While the receiver hunts, only the header value starts a frame.
                if (b == hdr_val)
                begin
                    cur_id  = 8'h00;
                    cur_len = 8'h00;
                    pay_cnt = 8'h00;
                    xor_acc = b;
                    rx_ph   = fsr_pkg::PH_ID;
                end
                else
                begin
                    w.status = fsr_pkg::ST_HUNT;
                    rx_ph    = fsr_pkg::PH_HEADER;
                end
            end
        endcase
        if (w.status != fsr_pkg::ST_HUNT)
        begin
            w.frame_id = cur_id;
            w.plength  = cur_len;
        end
        return w;
    endfunction

    // Offers one byte on the slave port. The sender works in bursts, and a random gap opens
    // before each burst. The task is entered and left at a falling edge. When the byte is
    // accepted, the expected status word goes into the queue.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        status_q.push_back(receive_byte(b));
        words_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Stops the sender, waits until every expected word has come out and then waits out
    // the drain period, so that the block is idle for certain.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes one register. The write takes effect at a rising clock edge, and the predictor
    // copy is updated after that edge.
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        case (idx)
            fsr_pkg::REG_HEADER_BYTE:  hdr_val = val;
            fsr_pkg::REG_FOOTER_BYTE:  ftr_val = val;
            fsr_pkg::REG_PAYLOAD_ID_A: pid[0]  = val;
            fsr_pkg::REG_PAYLOAD_ID_B: pid[1]  = val;
            fsr_pkg::REG_PAYLOAD_ID_C: pid[2]  = val;
            fsr_pkg::REG_PAYLOAD_ID_D: pid[3]  = val;
            default: ;
        endcase
    endtask

    // Loads a complete register setting while the block is idle. Random data also goes to the
    // two spare indexes, and those writes must not show up anywhere.
    task automatic program_regs(input logic [7:0] hdr, input logic [7:0] ftr,
                                input logic [7:0] id_a, input logic [7:0] id_b,
                                input logic [7:0] id_c, input logic [7:0] id_d);
        logic [7:0] junk;
        drain_results();
        write_reg(fsr_pkg::REG_HEADER_BYTE, hdr);
        write_reg(fsr_pkg::REG_FOOTER_BYTE, ftr);
        write_reg(fsr_pkg::REG_PAYLOAD_ID_A, id_a);
        write_reg(fsr_pkg::REG_PAYLOAD_ID_B, id_b);
        write_reg(fsr_pkg::REG_PAYLOAD_ID_C, id_c);
        write_reg(fsr_pkg::REG_PAYLOAD_ID_D, id_d);
        junk = 8'($urandom);
        write_reg(REG_SPARE_LO, junk);
        junk = 8'($urandom);
        write_reg(REG_SPARE_HI, junk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sends one frame under the current setting. Most frames are well formed, with random
    // content. Some frames stop after the id, some carry a bad length byte, and some carry
    // a corrupted checksum or a wrong footer. A fixed_len of zero or more forces a good frame
    // with a payload id and a payload of that length.
    task automatic send_frame(input int fixed_len);
        logic [7:0] fid;
        logic [7:0] sum;
        logic [7:0] b;
        int         kind;
        int         n;
        kind = (fixed_len >= 0) ? 50 : $urandom_range(0, 99);
        if (fixed_len >= 0 || $urandom_range(0, 3) != 0)
            fid = pid[2'($urandom_range(0, 3))];
        else
            fid = 8'($urandom);
        send_byte(hdr_val);
        sum = hdr_val;
        send_byte(fid);
        sum = sum ^ fid;
        // This frame stops after the id. The next bytes land in the middle of the frame.
        if (kind < 5)
            return;
        if (carries_payload(fid))
        begin
            if (kind < 10)
            begin
                b = 8'($urandom_range(0, fsr_pkg::LEN_OFFSET - 1));
                send_byte(b);
                return;
            end
            if (fixed_len >= 0)
                n = fixed_len;
            else if (kind >= 98)
                n = $urandom_range(100, MAX_PAYLOAD);
            else
                n = $urandom_range(0, 8);
            b = 8'(n + fsr_pkg::LEN_OFFSET);
            send_byte(b);
            sum = sum ^ b;
            repeat (n)
            begin
                // The header value shows up inside payloads quite often.
                if ($urandom_range(0, 7) == 0)
                    b = hdr_val;
                else
                    b = 8'($urandom);
                send_byte(b);
                sum = sum ^ b;
            end
        end
        if (kind >= 10 && kind < 15)
        begin
            send_byte(sum ^ (8'h01 << $urandom_range(0, 7)));
            return;
        end
        send_byte(sum);
        if (kind >= 15 && kind < 20)
        begin
            b = 8'($urandom_range(1, 255));
            send_byte(ftr_val ^ b);
        end
        else
            send_byte(ftr_val);
    endtask

    // Sends a mix of frames and line noise until at least the given number of words has been
    // accepted. Noise bytes never take the header value, so frames start where they are meant to.
    task automatic run_traffic(input int words);
        int         stop_at;
        logic [7:0] b;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            repeat ($urandom_range(0, 3))
            begin
                b = 8'($urandom);
                if (b == hdr_val)
                    b = ~b;
                send_byte(b);
            end
            send_frame(-1);
        end
    endtask

    // The result side changes its ready pattern at random times. Some stretches have no stall,
    // some stall lightly or heavily, and some follow a fixed duty cycle.
    always @(negedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_run  = $urandom_range(20, 200);
        end
        ready_run--;
        cycle_no++;
        case (ready_mode)
            RDY_OPEN:  m_tready <= 1'b1;
            RDY_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RDY_HEAVY: m_tready <= ($urandom_range(0, 2) == 0);
            default:   m_tready <= ((cycle_no % 5) < 3);
        endcase
    end

    // Each accepted status word is compared with the oldest expected word. A word that arrives
    // while nothing is expected is a failure as well.
    always @(posedge clk)
    begin : check_word
        status_word_t got;
        status_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
            if (status_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected word status=%0d id=%h byte=%h index=%0d len=%0d",
                             $realtime, got.status, got.frame_id, got.pbyte, got.pindex,
                             got.plength);
            end
            else
            begin
                want = status_q.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("%0t: word mismatch, expected status=%0d id=%h byte=%h ",
                               $realtime, want.status, want.frame_id, want.pbyte);
                        $display("index=%0d len=%0d, got status=%0d id=%h byte=%h %s",
                                 want.pindex, want.plength, got.status, got.frame_id,
                                 got.pbyte, "");
                        $display("    got index=%0d len=%0d", got.pindex, got.plength);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] shared_id;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = fsr_pkg::REG_HEADER_BYTE;
        cfg_wdata = 8'h00;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        m_tready  = 1'b0;
        hdr_val   = fsr_pkg::HEADER_RESET;
        ftr_val   = fsr_pkg::FOOTER_RESET;
        pid[0]    = 8'h00;
        pid[1]    = 8'h00;
        pid[2]    = 8'h00;
        pid[3]    = 8'h00;
        rx_ph     = fsr_pkg::PH_HEADER;
        cur_id    = 8'h00;
        cur_len   = 8'h00;
        pay_cnt   = 8'h00;
        xor_acc   = 8'h00;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First the directed table runs under the reset setting. A typed row replaces the
        // predicted word with the word written in the table.
        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].rx);
            if (dir_rows[i].typed)
                status_q[status_q.size() - 1] = dir_rows[i].want;
        end

        // Next comes a random setting.
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
        run_traffic(PHASE_WORDS);

        // This setting holds the extreme values. It starts with one frame of the longest payload.
        program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F);
        send_frame(MAX_PAYLOAD);
        run_traffic(PHASE_WORDS);

        // Here the delimiters are swapped to the opposite extremes, and all four ids are the same.
        shared_id = 8'($urandom);
        program_regs(8'hFF, 8'h00, shared_id, shared_id, shared_id, shared_id);
        run_traffic(PHASE_WORDS);

        // The last setting is random again.
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
        run_traffic(PHASE_WORDS);

        drain_results();
        if (mismatch_count == 0 && status_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // This bound is far longer than the slowest correct run of the stimulus above.
    initial
    begin
        #TIMEOUT_NS;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fsr_pkg.sv
rtl/framed_serial_receiver.sv
verif/tb_framed_serial_receiver.sv
